/* hw/rtl/uhist_pkg.sv */
// types and constants shared by the uniform histogram accumulator
`timescale 1ns / 1ps
package uhist_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int SUM_W       = 48;
   localparam int INDEX_W     = 8;
   localparam int CSR_W       = 32;
   localparam int CSR_ADDR_W  = 2;
   localparam int BINS_USED_W = 9;
   localparam int STATUS_W    = 2;

   localparam logic CMD_ACCUMULATE = 1'b0;
   localparam logic CMD_READ       = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BIN   = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_LOW   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_HIGH  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INV_WIDTH   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BINS_USED   = 2'd3;

   localparam logic signed [SAMPLE_W-1:0] RANGE_LOW_RESET  = 32'sd0;
   localparam logic signed [SAMPLE_W-1:0] RANGE_HIGH_RESET = 32'sd16777216;
   localparam logic [SAMPLE_W-1:0]        INV_WIDTH_RESET  = 32'd65536;
   localparam logic [BINS_USED_W-1:0]     BINS_USED_RESET  = 9'd256;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic                       command;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] weight;
      logic [INDEX_W-1:0]         read_bin;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [INDEX_W-1:0]      bin_index;
      logic signed [SUM_W-1:0] bin_sum;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic capture;
      logic multiply;
      logic index;
      logic read;
      logic update;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
   } stat_type;

endpackage

/* hw/rtl/uhist_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module uhist_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/uhist_ctrl.sv */
// controller state machine of the uniform histogram accumulator
`timescale 1ns / 1ps
module uhist_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  uhist_pkg::stat_type stat,
   output uhist_pkg::cmd_type  cmd
);
   import uhist_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_INDEX  = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_UPDATE = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = ST_INDEX;
         end
         ST_INDEX: begin
            cmd.index = 1'b1;
            state_in  = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* hw/rtl/uhist_dp.sv */
// datapath: registers, bin index multiply, bin store and saturating update
`timescale 1ns / 1ps
module uhist_dp #(
   parameter int BINS      = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  uhist_pkg::cmd_type                   cmd,
   output uhist_pkg::stat_type                  stat,
   input  uhist_pkg::req_type                   req_data,
   input  logic                                 csr_wr_en,
   input  logic [uhist_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [uhist_pkg::CSR_W-1:0]          csr_wdata,
   output logic                                 rsp_strobe,
   output uhist_pkg::rsp_type                   rsp_data
);
   import uhist_pkg::*;

   localparam int IDX_W = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int CNT_W = $clog2(BINS + 1);
   localparam int NW    = (CNT_W > BINS_USED_W) ? CNT_W : BINS_USED_W;
   localparam int HI_W  = 2 * SAMPLE_W - 2 * FRAC_BITS;
   localparam int CMP_W = (HI_W > NW) ? HI_W : NW;

   // configuration
   logic signed [SAMPLE_W-1:0] range_low_ff;
   logic signed [SAMPLE_W-1:0] range_high_ff;
   logic [SAMPLE_W-1:0]        inv_width_ff;
   logic [BINS_USED_W-1:0]     bins_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
         inv_width_ff  <= INV_WIDTH_RESET;
         bins_used_ff  <= BINS_USED_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RANGE_LOW:  range_low_ff  <= csr_wdata;
            CSR_RANGE_HIGH: range_high_ff <= csr_wdata;
            CSR_INV_WIDTH:  inv_width_ff  <= csr_wdata;
            CSR_BINS_USED:  bins_used_ff  <= csr_wdata[BINS_USED_W-1:0];
            default: ;
         endcase
      end
   end

   // bins in use, forced into 1..BINS
   logic [NW-1:0]    n_bins;
   logic [IDX_W-1:0] last_bin;

   always_comb begin
      if (bins_used_ff == '0) begin
         n_bins = NW'(1);
      end else if (NW'(bins_used_ff) > NW'(BINS)) begin
         n_bins = NW'(BINS);
      end else begin
         n_bins = NW'(bins_used_ff);
      end
      last_bin = IDX_W'(n_bins - NW'(1));
   end

   // clearing pass
   logic [IDX_W-1:0] clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clear_cnt_ff <= clear_cnt_ff + IDX_W'(1);
      end
   end

   assign stat.clear_last = (clear_cnt_ff == IDX_W'(BINS - 1));

   // capture: range check and offset from the lower bound
   req_type                    req_ff;
   logic                       range_bad_ff;
   logic [SAMPLE_W-1:0]        diff_ff;
   logic signed [SAMPLE_W:0]   diff_full;

   assign diff_full = {req_data.sample[SAMPLE_W-1], req_data.sample}
                    - {range_low_ff[SAMPLE_W-1], range_low_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff       <= req_data;
         range_bad_ff <= (req_data.sample < range_low_ff)
                      || (req_data.sample > range_high_ff);
         diff_ff      <= diff_full[SAMPLE_W-1:0];
      end
   end

   // multiply
   logic [2*SAMPLE_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.multiply) begin
         prod_ff <= diff_ff * inv_width_ff;
      end
   end

   // index and status
   logic [HI_W-1:0]     idx_full;
   logic [IDX_W-1:0]    idx_in;
   logic [IDX_W-1:0]    idx_ff;
   logic [INDEX_W-1:0]  out_index_in;
   logic [INDEX_W-1:0]  out_index_ff;
   logic [STATUS_W-1:0] status_in;
   logic [STATUS_W-1:0] status_ff;

   assign idx_full = prod_ff[2*SAMPLE_W-1:2*FRAC_BITS];

   always_comb begin
      if (req_ff.command == CMD_READ) begin
         idx_in       = IDX_W'(req_ff.read_bin);
         out_index_in = req_ff.read_bin;
         status_in    = (NW'(req_ff.read_bin) >= n_bins) ? STATUS_BIN : STATUS_OK;
      end else begin
         // past the last bin (upper bound, rounding) saturates to the last bin
         if (CMP_W'(idx_full) >= CMP_W'(n_bins)) begin
            idx_in = last_bin;
         end else begin
            idx_in = IDX_W'(idx_full);
         end
         status_in    = range_bad_ff ? STATUS_RANGE : STATUS_OK;
         out_index_in = range_bad_ff ? '0 : INDEX_W'(idx_in);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.index) begin
         idx_ff       <= idx_in;
         out_index_ff <= out_index_in;
         status_ff    <= status_in;
      end
   end

   // bin store
   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   logic signed [SUM_W-1:0] ram_wr_data;
   logic signed [SUM_W-1:0] ram_rd_data;

   uhist_ram #(
      .WIDTH (SUM_W),
      .DEPTH (BINS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.read),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // saturating update
   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] sum_sat;
   logic                    do_write;

   assign sum_wide = {ram_rd_data[SUM_W-1], ram_rd_data} + (SUM_W+1)'(req_ff.weight);

   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   assign do_write = cmd.update && (req_ff.command == CMD_ACCUMULATE)
                  && (status_ff == STATUS_OK);

   always_comb begin
      if (cmd.clear) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = do_write;
         ram_wr_addr = idx_ff;
         ram_wr_data = sum_sat;
      end
   end

   // result register
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   always_comb begin
      rsp_in.status    = status_ff;
      rsp_in.bin_index = out_index_ff;
      if (status_ff != STATUS_OK) begin
         rsp_in.bin_sum = '0;
      end else if (req_ff.command == CMD_READ) begin
         rsp_in.bin_sum = ram_rd_data;
      end else begin
         rsp_in.bin_sum = sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* hw/rtl/uniform_histogram_accumulator.sv */
// top level of the uniform-bin weighted histogram accumulator
// result: the strobe is registered in the update step, after the multiply, index and bin store read steps
// one transaction at a time: a new one is taken only in idle, after the multiply, index and bin store
//   read-modify-write steps of the controller; busy drops while the strobe shows
// reset: synchronous; the bin store is then cleared bin by bin with busy high
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps
module uniform_histogram_accumulator #(
   parameter int BINS      = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  uhist_pkg::req_type               req_data,
   output logic                             rsp_strobe,
   output uhist_pkg::rsp_type               rsp_data,
   input  logic                             csr_wr_en,
   input  logic [uhist_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [uhist_pkg::CSR_W-1:0]      csr_wdata
);
   import uhist_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   uhist_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   uhist_dp #(
      .BINS      (BINS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_data   (req_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

/* hw/rtl/uhist_checker.sv */
// port-level checks of the histogram accumulator and their bind
`timescale 1ns / 1ps
module uhist_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_strobe,
   input uhist_pkg::rsp_type               rsp_data
);
   import uhist_pkg::*;

   // every accepted transaction gives its result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_strobe)
      else $error("result strobe missing after accepted transaction");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == STATUS_RANGE)
         |-> (rsp_data.bin_index == '0 && rsp_data.bin_sum == '0))
      else $error("rejected sample with nonzero index or sum");

   a_bad_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == STATUS_BIN) |-> (rsp_data.bin_sum == '0))
      else $error("read beyond bins with nonzero sum");

endmodule

bind uniform_histogram_accumulator uhist_checker u_checker (.*);
